// ----- design/acfz_pkg.sv -----
// acfz_pkg: shared constants, codes, control word type and microcode rom
// for the altitude complementary filter. no dependencies.
`timescale 1ns / 1ps

package acfz_pkg;

   // field widths
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int DT_W       = 16;
   localparam int GAIN_W     = 24;
   localparam int THR_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // acceleration window
   localparam int WINDOW_LEN = 8;
   localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int WIN_CNT_W  = $clog2(WINDOW_LEN + 1);

   // datapath widths
   localparam int D_W    = DATA_W + 1;
   localparam int REG_W  = 49;
   localparam int OPB_W  = 25;
   localparam int PROD_W = 66;
   localparam int PC_W   = 4;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [GAIN_W-1:0] POS_GAIN_RST  = 24'd65536;
   localparam logic [GAIN_W-1:0] VEL_GAIN_RST  = 24'd65536;
   localparam logic [THR_W-1:0]  THRESHOLD_RST = 31'd6554;

   // operand sources
   localparam logic [3:0] SRC_BARO = 4'd0;
   localparam logic [3:0] SRC_PA   = 4'd1;
   localparam logic [3:0] SRC_PV   = 4'd2;
   localparam logic [3:0] SRC_ACC  = 4'd3;
   localparam logic [3:0] SRC_DT   = 4'd4;
   localparam logic [3:0] SRC_G0   = 4'd5;
   localparam logic [3:0] SRC_G1   = 4'd6;
   localparam logic [3:0] SRC_D    = 4'd7;
   localparam logic [3:0] SRC_K    = 4'd8;
   localparam logic [3:0] SRC_T    = 4'd9;
   localparam logic [3:0] SRC_V    = 4'd10;
   localparam logic [3:0] SRC_W    = 4'd11;

   // alu operations
   localparam logic [2:0] ALU_NOP  = 3'd0;
   localparam logic [2:0] ALU_ADD  = 3'd1;
   localparam logic [2:0] ALU_SUB  = 3'd2;
   localparam logic [2:0] ALU_RND  = 3'd3;
   localparam logic [2:0] ALU_MOVP = 3'd4;
   localparam logic [2:0] ALU_PADD = 3'd5;

   // alu destinations
   localparam logic [2:0] DST_D = 3'd0;
   localparam logic [2:0] DST_K = 3'd1;
   localparam logic [2:0] DST_T = 3'd2;
   localparam logic [2:0] DST_V = 3'd3;
   localparam logic [2:0] DST_W = 3'd4;

   // rounding shifts
   localparam logic [1:0] RND_16 = 2'd0;
   localparam logic [1:0] RND_17 = 2'd1;
   localparam logic [1:0] RND_33 = 2'd2;

   // sequencer jump conditions
   localparam logic [1:0] JC_NEXT   = 2'd0;
   localparam logic [1:0] JC_JUMP   = 2'd1;
   localparam logic [1:0] JC_START  = 2'd2;
   localparam logic [1:0] JC_FINISH = 2'd3;

   typedef struct packed {
      logic            mul_en;
      logic [3:0]      a_sel;
      logic [3:0]      b_sel;
      logic [2:0]      alu_op;
      logic [3:0]      x_sel;
      logic [3:0]      y_sel;
      logic [1:0]      rnd_sel;
      logic [2:0]      dst;
      logic [1:0]      jc;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic idle;
      logic finish;
   } seq_stat_type;

   typedef struct packed {
      logic done;
      logic moving;
   } win_stat_type;

   // microcode: one control word per step, multiplier and alu run side by side
   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type cw;
      cw = '0;
      cw.alu_op = ALU_NOP;
      cw.jc = JC_NEXT;
      case (pc)
         4'd0: begin
            cw.jc = JC_START;
         end
         4'd1: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_DT; cw.b_sel = SRC_G1;
            cw.alu_op = ALU_SUB; cw.x_sel = SRC_BARO; cw.y_sel = SRC_PA; cw.dst = DST_D;
         end
         4'd2: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_ACC; cw.b_sel = SRC_DT;
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_17; cw.dst = DST_T;
         end
         4'd3: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_D; cw.b_sel = SRC_G1;
            cw.alu_op = ALU_MOVP; cw.dst = DST_V;
         end
         4'd4: begin
            cw.alu_op = ALU_PADD;
         end
         4'd5: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_V; cw.b_sel = SRC_DT;
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_16; cw.dst = DST_W;
         end
         4'd6: begin
            cw.alu_op = ALU_ADD; cw.x_sel = SRC_T; cw.y_sel = SRC_G0; cw.dst = DST_K;
         end
         4'd7: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_D; cw.b_sel = SRC_K;
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_33; cw.dst = DST_V;
         end
         4'd8: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_W; cw.b_sel = SRC_DT;
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_16; cw.dst = DST_T;
         end
         4'd9: begin
            cw.alu_op = ALU_ADD; cw.x_sel = SRC_T; cw.y_sel = SRC_PV; cw.dst = DST_T;
         end
         4'd10: begin
            cw.mul_en = 1'b1; cw.a_sel = SRC_T; cw.b_sel = SRC_DT;
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_16; cw.dst = DST_W;
         end
         4'd11: begin
            cw.alu_op = ALU_RND; cw.rnd_sel = RND_16; cw.dst = DST_T;
         end
         4'd12: begin
            cw.alu_op = ALU_ADD; cw.x_sel = SRC_W; cw.y_sel = SRC_PV; cw.dst = DST_W;
         end
         4'd13: begin
            cw.alu_op = ALU_ADD; cw.x_sel = SRC_T; cw.y_sel = SRC_PA; cw.dst = DST_T;
         end
         4'd14: begin
            cw.alu_op = ALU_ADD; cw.x_sel = SRC_T; cw.y_sel = SRC_V; cw.dst = DST_T;
         end
         4'd15: begin
            cw.jc = JC_FINISH; cw.target = '0;
         end
         default: begin
            cw.jc = JC_JUMP; cw.target = '0;
         end
      endcase
      return cw;
   endfunction

endpackage

// ----- design/acfz_seq.sv -----
// acfz_seq: step counter and microcode sequencer with conditional jumps.
// depends on acfz_pkg for the control word type and the rom.
`timescale 1ns / 1ps

module acfz_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   input  logic                  scan_done,
   output acfz_pkg::ctrl_type    cw,
   output acfz_pkg::seq_stat_type stat
);

   logic [acfz_pkg::PC_W-1:0] pc_ff;
   logic [acfz_pkg::PC_W-1:0] pc_in;
   logic                      can_finish;

   assign cw = acfz_pkg::ucode_rom(pc_ff);
   assign can_finish = scan_done && out_free;

   always_comb begin
      pc_in = pc_ff;
      case (cw.jc)
         acfz_pkg::JC_NEXT: begin
            pc_in = acfz_pkg::PC_W'(pc_ff + 1'b1);
         end
         acfz_pkg::JC_JUMP: begin
            pc_in = cw.target;
         end
         acfz_pkg::JC_START: begin
            if (start) begin
               pc_in = acfz_pkg::PC_W'(pc_ff + 1'b1);
            end
         end
         acfz_pkg::JC_FINISH: begin
            // hold until the window scan is over and the result slot is free
            if (can_finish) begin
               pc_in = cw.target;
            end
         end
         default: begin
            pc_in = cw.target;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign stat.idle   = (cw.jc == acfz_pkg::JC_START);
   assign stat.finish = (cw.jc == acfz_pkg::JC_FINISH) && can_finish;

endmodule

// ----- design/acfz_win.sv -----
// acfz_win: acceleration ring window with valid bits and a one-entry-per-cycle
// stillness scan. depends on acfz_pkg for widths and the status type.
`timescale 1ns / 1ps

module acfz_win (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [acfz_pkg::DATA_W-1:0]  accel,
   input  logic [acfz_pkg::THR_W-1:0]          threshold,
   output acfz_pkg::win_stat_type              stat
);

   logic signed [acfz_pkg::DATA_W-1:0] mem [acfz_pkg::WINDOW_LEN];
   logic signed [acfz_pkg::DATA_W-1:0] rd_data_ff;

   logic [acfz_pkg::WINDOW_LEN-1:0] vld_ff, vld_in;
   logic [acfz_pkg::WIN_IDX_W-1:0]  pos_ff, pos_in;
   logic [acfz_pkg::WIN_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            pend_ff, pend_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            moving_ff, moving_in;

   logic [acfz_pkg::WIN_IDX_W-1:0]  idx;
   logic                            scan_end;
   logic [acfz_pkg::DATA_W-1:0]     mag;

   assign idx      = cnt_ff[acfz_pkg::WIN_IDX_W-1:0];
   assign scan_end = (cnt_ff == acfz_pkg::WIN_CNT_W'(acfz_pkg::WINDOW_LEN));
   // most negative sample gives 2^31, no wrap in the unsigned view
   assign mag = rd_data_ff[acfz_pkg::DATA_W-1] ? (~rd_data_ff + 1'b1) : rd_data_ff;

   always_comb begin
      vld_in    = vld_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      rd_vld_in = rd_vld_ff;
      moving_in = moving_ff;
      if (start) begin
         vld_in[pos_ff] = 1'b1;
         pos_in = (pos_ff == acfz_pkg::WIN_IDX_W'(acfz_pkg::WINDOW_LEN - 1)) ? '0
                : acfz_pkg::WIN_IDX_W'(pos_ff + 1'b1);
         cnt_in    = '0;
         moving_in = 1'b0;
      end else begin
         if (pend_ff && rd_vld_ff && (mag > {1'b0, threshold})) begin
            moving_in = 1'b1;
         end
         if (!scan_end) begin
            pend_in   = 1'b1;
            rd_vld_in = vld_ff[idx];
            cnt_in    = acfz_pkg::WIN_CNT_W'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         pos_ff    <= '0;
         cnt_ff    <= acfz_pkg::WIN_CNT_W'(acfz_pkg::WINDOW_LEN);
         pend_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         moving_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         rd_vld_ff <= rd_vld_in;
         moving_ff <= moving_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mem[pos_ff] <= accel;
      end
      rd_data_ff <= mem[idx];
   end

   assign stat.done   = scan_end && !pend_ff;
   assign stat.moving = moving_ff;

endmodule

// ----- design/acfz_dp.sv -----
// acfz_dp: filter datapath run by the microcode: item registers, shared
// multiplier with product register, alu with rounding. depends on acfz_pkg.
`timescale 1ns / 1ps

module acfz_dp (
   input  logic                                clock,
   input  logic                                start,
   input  acfz_pkg::ctrl_type                  cw,
   input  logic signed [acfz_pkg::DATA_W-1:0]  baro_altitude,
   input  logic signed [acfz_pkg::DATA_W-1:0]  prior_altitude,
   input  logic signed [acfz_pkg::DATA_W-1:0]  prior_velocity,
   input  logic signed [acfz_pkg::DATA_W-1:0]  vert_accel,
   input  logic [acfz_pkg::DT_W-1:0]           time_step,
   input  logic [acfz_pkg::GAIN_W-1:0]         position_gain,
   input  logic [acfz_pkg::GAIN_W-1:0]         velocity_gain,
   output logic signed [acfz_pkg::DATA_W-1:0]  alt_sat,
   output logic signed [acfz_pkg::DATA_W-1:0]  vel_sat
);

   localparam int RW = acfz_pkg::REG_W;
   localparam int PW = acfz_pkg::PROD_W;

   logic signed [acfz_pkg::DATA_W-1:0] baro_ff, baro_in, pa_ff, pa_in;
   logic signed [acfz_pkg::DATA_W-1:0] pv_ff, pv_in, acc_ff, acc_in;
   logic [acfz_pkg::DT_W-1:0]          dt_ff, dt_in;
   logic signed [acfz_pkg::D_W-1:0]    d_ff, d_in;
   logic [acfz_pkg::OPB_W-1:0]         k_ff, k_in;
   logic signed [RW-1:0]               t_ff, t_in, v_ff, v_in, w_ff, w_in;
   logic signed [PW-1:0]               prod_ff, prod_in;

   logic signed [RW-1:0]               a_op, b_full, x_op, y_op, alu_res;
   logic [acfz_pkg::OPB_W-1:0]         b_op;
   logic signed [RW+acfz_pkg::OPB_W:0] mul_full;
   logic signed [PW-1:0]               acc_scaled;
   logic                               alu_wr;

   function automatic logic signed [RW-1:0] pick(input logic [3:0] sel);
      logic signed [RW-1:0] r;
      case (sel)
         acfz_pkg::SRC_BARO: r = RW'(baro_ff);
         acfz_pkg::SRC_PA:   r = RW'(pa_ff);
         acfz_pkg::SRC_PV:   r = RW'(pv_ff);
         acfz_pkg::SRC_ACC:  r = RW'(acc_ff);
         acfz_pkg::SRC_DT:   r = $signed(RW'(dt_ff));
         acfz_pkg::SRC_G0:   r = $signed(RW'(position_gain));
         acfz_pkg::SRC_G1:   r = $signed(RW'(velocity_gain));
         acfz_pkg::SRC_D:    r = RW'(d_ff);
         acfz_pkg::SRC_K:    r = $signed(RW'(k_ff));
         acfz_pkg::SRC_T:    r = t_ff;
         acfz_pkg::SRC_V:    r = v_ff;
         acfz_pkg::SRC_W:    r = w_ff;
         default:            r = '0;
      endcase
      return r;
   endfunction

   // round to nearest, ties away from zero
   function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] x,
                                                input logic [1:0] sel);
      logic [5:0]           amt;
      logic signed [PW-1:0] s;
      logic signed [PW-1:0] q;
      case (sel)
         acfz_pkg::RND_16: amt = 6'd16;
         acfz_pkg::RND_17: amt = 6'd17;
         acfz_pkg::RND_33: amt = 6'd33;
         default:          amt = 6'd16;
      endcase
      s = x + (PW'(1) << (amt - 6'd1)) - PW'(x[PW-1]);
      q = s >>> amt;
      return q[RW-1:0];
   endfunction

   function automatic logic signed [acfz_pkg::DATA_W-1:0] sat(input logic signed [RW-1:0] x);
      logic signed [RW-1:0] hi;
      logic signed [RW-1:0] lo;
      hi = {{(RW - acfz_pkg::DATA_W + 1){1'b0}}, {(acfz_pkg::DATA_W - 1){1'b1}}};
      lo = ~hi;
      if (x > hi) begin
         return hi[acfz_pkg::DATA_W-1:0];
      end else if (x < lo) begin
         return lo[acfz_pkg::DATA_W-1:0];
      end
      return x[acfz_pkg::DATA_W-1:0];
   endfunction

   always_comb begin
      a_op   = pick(cw.a_sel);
      b_full = pick(cw.b_sel);
      b_op   = b_full[acfz_pkg::OPB_W-1:0];
      x_op   = pick(cw.x_sel);
      y_op   = pick(cw.y_sel);
   end

   assign mul_full   = a_op * $signed({1'b0, b_op});
   assign acc_scaled = PW'(acc_ff) <<< acfz_pkg::FRAC_W;

   always_comb begin
      alu_wr  = 1'b1;
      alu_res = '0;
      case (cw.alu_op)
         acfz_pkg::ALU_ADD:  alu_res = x_op + y_op;
         acfz_pkg::ALU_SUB:  alu_res = x_op - y_op;
         acfz_pkg::ALU_RND:  alu_res = rnd(prod_ff, cw.rnd_sel);
         acfz_pkg::ALU_MOVP: alu_res = prod_ff[RW-1:0];
         default:            alu_wr  = 1'b0;
      endcase
   end

   always_comb begin
      baro_in = baro_ff;
      pa_in   = pa_ff;
      pv_in   = pv_ff;
      acc_in  = acc_ff;
      dt_in   = dt_ff;
      d_in    = d_ff;
      k_in    = k_ff;
      t_in    = t_ff;
      v_in    = v_ff;
      w_in    = w_ff;
      prod_in = prod_ff;
      if (start) begin
         baro_in = baro_altitude;
         pa_in   = prior_altitude;
         pv_in   = prior_velocity;
         acc_in  = vert_accel;
         dt_in   = time_step;
      end
      if (cw.mul_en) begin
         prod_in = mul_full[PW-1:0];
      end else if (cw.alu_op == acfz_pkg::ALU_PADD) begin
         prod_in = prod_ff + acc_scaled;
      end
      if (alu_wr) begin
         case (cw.dst)
            acfz_pkg::DST_D: d_in = alu_res[acfz_pkg::D_W-1:0];
            acfz_pkg::DST_K: k_in = alu_res[acfz_pkg::OPB_W-1:0];
            acfz_pkg::DST_T: t_in = alu_res;
            acfz_pkg::DST_V: v_in = alu_res;
            acfz_pkg::DST_W: w_in = alu_res;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      baro_ff <= baro_in;
      pa_ff   <= pa_in;
      pv_ff   <= pv_in;
      acc_ff  <= acc_in;
      dt_ff   <= dt_in;
      d_ff    <= d_in;
      k_ff    <= k_in;
      t_ff    <= t_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
   end

   assign alt_sat = sat(t_ff);
   assign vel_sat = sat(w_ff);

endmodule

// ----- design/altitude_complementary_filter_zupt.sv -----
// altitude_complementary_filter_zupt: top level with handshakes, config
// registers and result register. depends on acfz_pkg, acfz_seq, acfz_dp, acfz_win.
// one item at a time: a new item is taken only when the sequencer is back at its idle step,
// and the result is held until the window scan is over and the result register is free;
// the 16-step microcode shares one multiplier and one alu.
// reset: gains and threshold to defaults, window empty (reads as zero), sequencer idle.
`timescale 1ns / 1ps

module altitude_complementary_filter_zupt (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [acfz_pkg::DATA_W-1:0]      req_baro_altitude,
   input  logic signed [acfz_pkg::DATA_W-1:0]      req_prior_altitude,
   input  logic signed [acfz_pkg::DATA_W-1:0]      req_prior_velocity,
   input  logic signed [acfz_pkg::DATA_W-1:0]      req_vert_accel,
   input  logic [acfz_pkg::DT_W-1:0]               req_time_step,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [acfz_pkg::DATA_W-1:0]      rsp_new_altitude,
   output logic signed [acfz_pkg::DATA_W-1:0]      rsp_new_velocity,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [acfz_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [acfz_pkg::CSR_DATA_W-1:0]         csr_data
);

   logic [acfz_pkg::GAIN_W-1:0] pos_gain_ff, pos_gain_in;
   logic [acfz_pkg::GAIN_W-1:0] vel_gain_ff, vel_gain_in;
   logic [acfz_pkg::THR_W-1:0]  thr_ff, thr_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [acfz_pkg::DATA_W-1:0] alt_ff, alt_in, vel_ff, vel_in;

   logic                               start;
   logic                               out_free;
   logic signed [acfz_pkg::DATA_W-1:0] alt_sat, vel_sat;
   acfz_pkg::ctrl_type                 cw;
   acfz_pkg::seq_stat_type             seq_stat;
   acfz_pkg::win_stat_type             win_stat;

   assign req_ready = seq_stat.idle;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   acfz_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_free  (out_free),
      .scan_done (win_stat.done),
      .cw        (cw),
      .stat      (seq_stat)
   );

   acfz_dp u_dp (
      .clock          (clock),
      .start          (start),
      .cw             (cw),
      .baro_altitude  (req_baro_altitude),
      .prior_altitude (req_prior_altitude),
      .prior_velocity (req_prior_velocity),
      .vert_accel     (req_vert_accel),
      .time_step      (req_time_step),
      .position_gain  (pos_gain_ff),
      .velocity_gain  (vel_gain_ff),
      .alt_sat        (alt_sat),
      .vel_sat        (vel_sat)
   );

   acfz_win u_win (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .accel     (req_vert_accel),
      .threshold (thr_ff),
      .stat      (win_stat)
   );

   always_comb begin
      pos_gain_in = pos_gain_ff;
      vel_gain_in = vel_gain_ff;
      thr_in      = thr_ff;
      if (csr_valid) begin
         case (csr_index)
            acfz_pkg::CSR_POS_GAIN:  pos_gain_in = csr_data[acfz_pkg::GAIN_W-1:0];
            acfz_pkg::CSR_VEL_GAIN:  vel_gain_in = csr_data[acfz_pkg::GAIN_W-1:0];
            acfz_pkg::CSR_THRESHOLD: thr_in      = csr_data[acfz_pkg::THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      alt_in       = alt_ff;
      vel_in       = vel_ff;
      if (seq_stat.finish) begin
         rsp_valid_in = 1'b1;
         alt_in       = alt_sat;
         // zero velocity when nothing in the window moved
         vel_in       = win_stat.moving ? vel_sat : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_gain_ff  <= acfz_pkg::POS_GAIN_RST;
         vel_gain_ff  <= acfz_pkg::VEL_GAIN_RST;
         thr_ff       <= acfz_pkg::THRESHOLD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_gain_ff  <= pos_gain_in;
         vel_gain_ff  <= vel_gain_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alt_ff <= alt_in;
      vel_ff <= vel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_altitude = alt_ff;
   assign rsp_new_velocity = vel_ff;

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer still idle after taking an item");

   a_finish_scan: assert property (@(posedge clock) disable iff (reset)
      seq_stat.finish |-> win_stat.done)
      else $error("result finished before window scan");

   a_still_zero: assert property (@(posedge clock) disable iff (reset)
      (seq_stat.finish && !win_stat.moving) |=> (rsp_new_velocity == '0))
      else $error("still window gave nonzero velocity");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      seq_stat.finish |=> rsp_valid)
      else $error("finished item not presented");

endmodule

// ----- sim/altitude_complementary_filter_zupt_tb.sv -----
// altitude_complementary_filter_zupt_tb: self-checking testbench for the altitude
// complementary filter with zero-velocity update; a directed table, then random items
// over several gain/threshold settings. depends on acfz_pkg and the design sources.
`timescale 1ns / 1ps

module altitude_complementary_filter_zupt_tb;

   localparam int SETTINGS_COUNT = 6;
   localparam int ITEMS_PER_SETTING = 88;
   localparam int SCRIPT_ROWS = 23;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [acfz_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef logic signed [95:0] wide_type;
   localparam wide_type S32_MAX = 96'sd2147483647;
   localparam wide_type S32_MIN = -96'sd2147483648;

   typedef struct packed {
      logic signed [acfz_pkg::DATA_W-1:0] baro;
      logic signed [acfz_pkg::DATA_W-1:0] prior_alt;
      logic signed [acfz_pkg::DATA_W-1:0] prior_vel;
      logic signed [acfz_pkg::DATA_W-1:0] accel;
      logic [acfz_pkg::DT_W-1:0]          dt;
   } sensor_item_type;

   typedef struct packed {
      logic signed [acfz_pkg::DATA_W-1:0] alt;
      logic signed [acfz_pkg::DATA_W-1:0] vel;
   } estimate_type;

   typedef struct packed {
      sensor_item_type item;
      logic            fixed_result;
      estimate_type    result;
   } script_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [acfz_pkg::DATA_W-1:0] req_baro_altitude;
   logic signed [acfz_pkg::DATA_W-1:0] req_prior_altitude;
   logic signed [acfz_pkg::DATA_W-1:0] req_prior_velocity;
   logic signed [acfz_pkg::DATA_W-1:0] req_vert_accel;
   logic [acfz_pkg::DT_W-1:0] req_time_step;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [acfz_pkg::DATA_W-1:0] rsp_new_altitude;
   logic signed [acfz_pkg::DATA_W-1:0] rsp_new_velocity;
   logic csr_valid;
   logic csr_ready;
   logic [acfz_pkg::CSR_IDX_W-1:0] csr_index;
   logic [acfz_pkg::CSR_DATA_W-1:0] csr_data;

   // filter model state and register copies
   logic [acfz_pkg::GAIN_W-1:0] pos_gain;
   logic [acfz_pkg::GAIN_W-1:0] vel_gain;
   logic [acfz_pkg::THR_W-1:0] still_thr;
   logic signed [acfz_pkg::DATA_W-1:0] accel_hist [acfz_pkg::WINDOW_LEN];
   logic [acfz_pkg::WIN_IDX_W-1:0] hist_pos;

   estimate_type expected_estimates [$];
   int mismatches;
   int send_idle_pct;
   int recv_idle_pct;
   int still_run;
   bit hold_req;
   bit hold_done;

   altitude_complementary_filter_zupt DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_baro_altitude  (req_baro_altitude),
      .req_prior_altitude (req_prior_altitude),
      .req_prior_velocity (req_prior_velocity),
      .req_vert_accel     (req_vert_accel),
      .req_time_step      (req_time_step),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_altitude   (rsp_new_altitude),
      .rsp_new_velocity   (rsp_new_velocity),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // round to nearest, ties away from zero
   function automatic wide_type round_away(input wide_type x, input int s);
      wide_type mag;
      wide_type one;
      wide_type r;
      one = wide_type'(1);
      mag = (x < 0) ? -x : x;
      r = (mag + (one <<< (s - 1))) >>> s;
      return (x < 0) ? -r : r;
   endfunction

   function automatic logic signed [acfz_pkg::DATA_W-1:0] clamp32(input wide_type x);
      if (x > S32_MAX) return S32_MAX[acfz_pkg::DATA_W-1:0];
      if (x < S32_MIN) return S32_MIN[acfz_pkg::DATA_W-1:0];
      return x[acfz_pkg::DATA_W-1:0];
   endfunction

   function automatic estimate_type filter_update(input sensor_item_type s);
      wide_type b, pa, pv, a, t, g0, g1, thr;
      wide_type d, k, t1, t2, t3, w, m;
      estimate_type e;
      bit moving;
      b = wide_type'(s.baro);
      pa = wide_type'(s.prior_alt);
      pv = wide_type'(s.prior_vel);
      a = wide_type'(s.accel);
      t = wide_type'(s.dt);
      g0 = wide_type'(pos_gain);
      g1 = wide_type'(vel_gain);
      thr = wide_type'(still_thr);
      d = b - pa;
      k = g0 + round_away(g1 * t, 17);
      t1 = round_away(k * d, 16);
      t2 = round_away(t * (pv + t1), 16);
      t3 = round_away(a * t * t, 33);
      e.alt = clamp32(pa + t2 + t3);
      w = round_away(g1 * d + a * 65536, 16);
      e.vel = clamp32(pv + round_away(t * w, 16));
      // the new sample is part of the stillness test
      accel_hist[hist_pos] = s.accel;
      hist_pos = (hist_pos == acfz_pkg::WIN_IDX_W'(acfz_pkg::WINDOW_LEN - 1)) ? '0
               : acfz_pkg::WIN_IDX_W'(hist_pos + 1'b1);
      moving = 1'b0;
      for (int i = 0; i < acfz_pkg::WINDOW_LEN; i++) begin
         m = wide_type'(accel_hist[acfz_pkg::WIN_IDX_W'(i)]);
         if (m < 0) m = -m;
         if (m > thr) moving = 1'b1;
      end
      if (!moving) e.vel = '0;
      return e;
   endfunction

   function automatic script_row_type script_row(input int i);
      case (i)
         0: return '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'h0000}, 1'b1,
                     '{32'sh0, 32'sh0}};
         1: return '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678, 32'sh7FFFFFFF,
                       16'h0000}, 1'b1, '{32'sh80000000, 32'sh12345678}};
         2: return '{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                       16'h0000}, 1'b1, '{32'sh7FFFFFFF, 32'sh80000000}};
         3: return '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                       16'hFFFF}, 1'b1, '{32'sh7FFFFFFF, 32'sh7FFFFFFF}};
         4: return '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                       16'hFFFF}, 1'b1, '{32'sh80000000, 32'sh80000000}};
         5: return '{'{32'sh55555555, 32'sh00010000, 32'sh00020000, 32'sd6554,
                       16'h0000}, 1'b1, '{32'sh00010000, 32'sh00020000}};
         6: return '{'{32'sh00030000, 32'sh00010000, 32'shFFFF0000, -32'sd6554,
                       16'h8000}, 1'b0, '0};
         7: return '{'{32'shFFFE8000, 32'sh00020000, 32'sh00004000, 32'sd6555,
                       16'h0001}, 1'b0, '0};
         // eight quiet samples flush the window
         8: return '{'{32'sh00100000, 32'sh000F0000, 32'sh0, 32'sh00001000,
                       16'h1000}, 1'b0, '0};
         9: return '{'{32'shAAAAAAAA, 32'sh55555555, 32'sh0000ABCD, -32'sd1,
                       16'hFFFF}, 1'b0, '0};
         10: return '{'{32'sh0, 32'sh0, 32'sh00010000, 32'sh0, 16'h4000}, 1'b0, '0};
         11: return '{'{32'sh12345678, 32'sh12340000, 32'shFFFFFFFF, 32'sd6554,
                        16'h0100}, 1'b0, '0};
         12: return '{'{32'shF0000000, 32'shF0001000, 32'sh00008000, -32'sh00000800,
                        16'hABCD}, 1'b0, '0};
         13: return '{'{32'sh00020000, 32'sh00020000, 32'sh00050000, 32'sd1,
                        16'h0002}, 1'b0, '0};
         14: return '{'{32'shFFFF0000, 32'sh0, 32'sh7FFF0000, -32'sd6553,
                        16'h7FFF}, 1'b0, '0};
         15: return '{'{32'sh0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sd6554,
                        16'h0000}, 1'b1, '{32'sh7FFFFFFF, 32'sh0}};
         16: return '{'{32'sh0, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh80000000,
                        16'h0000}, 1'b1, '{32'shFFFFFFFF, 32'shFFFFFFFF}};
         17: return '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'hFFFF}, 1'b0, '0};
         18: return '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh00010000,
                        16'hFFFF}, 1'b0, '0};
         19: return '{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'shFFFF0000,
                        16'h0001}, 1'b0, '0};
         20: return '{'{32'sh0, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 16'hFFFF}, 1'b0, '0};
         21: return '{'{32'sh01000000, 32'sh00FF0000, 32'sh00100000, 32'shFFFF8000,
                        16'h2000}, 1'b0, '0};
         default: return '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'h0001}, 1'b0, '0};
      endcase
   endfunction

   function automatic logic signed [acfz_pkg::DATA_W-1:0] quiet_accel();
      logic [acfz_pkg::DATA_W-1:0] mag;
      mag = $urandom_range(0, {1'b0, still_thr});
      return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic sensor_item_type random_item();
      sensor_item_type s;
      logic signed [acfz_pkg::DATA_W-1:0] r;
      logic [acfz_pkg::DATA_W-1:0] edge_mag;
      r = $urandom;
      s.prior_alt = $urandom_range(0, 1) ? r : (r >>> $urandom_range(4, 24));
      r = $urandom;
      s.baro = $urandom_range(0, 1) ? s.prior_alt + (r >>> $urandom_range(6, 30)) : $urandom;
      r = $urandom;
      s.prior_vel = r >>> $urandom_range(0, 24);
      if (still_run > 0) begin
         still_run--;
         s.accel = quiet_accel();
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // a quiet stretch long enough to clear the window
               still_run = $urandom_range(7, 13);
               s.accel = quiet_accel();
            end
            2: begin
               edge_mag = {1'b0, still_thr} + $urandom_range(0, 1);
               s.accel = $urandom_range(0, 1) ? -$signed(edge_mag) : $signed(edge_mag);
            end
            3: begin
               case ($urandom_range(0, 3))
                  0: s.accel = 32'sh80000000;
                  1: s.accel = 32'sh7FFFFFFF;
                  2: s.accel = 32'sh0;
                  default: s.accel = -32'sd1;
               endcase
            end
            default: begin
               r = $urandom;
               s.accel = r >>> $urandom_range(0, 16);
            end
         endcase
      end
      case ($urandom_range(0, 7))
         0: s.dt = '0;
         1: s.dt = '1;
         2: s.dt = acfz_pkg::DT_W'($urandom_range(0, 255));
         default: s.dt = acfz_pkg::DT_W'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_item(input sensor_item_type s, input logic fixed_result,
                            input estimate_type fixed_est);
      estimate_type e;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_baro_altitude = s.baro;
      req_prior_altitude = s.prior_alt;
      req_prior_velocity = s.prior_vel;
      req_vert_accel = s.accel;
      req_time_step = s.dt;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      e = filter_update(s);
      if (fixed_result) e = fixed_est;
      expected_estimates.push_back(e);
   endtask

   task automatic write_reg(input logic [acfz_pkg::CSR_IDX_W-1:0] idx,
                            input logic [acfz_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         acfz_pkg::CSR_POS_GAIN: pos_gain = data[acfz_pkg::GAIN_W-1:0];
         acfz_pkg::CSR_VEL_GAIN: vel_gain = data[acfz_pkg::GAIN_W-1:0];
         acfz_pkg::CSR_THRESHOLD: still_thr = data[acfz_pkg::THR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop offering items and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_estimates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver: random back-pressure plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      estimate_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_estimates.size() == 0) begin
            $display("%0t: unexpected result: expected none, got alt %h vel %h",
                     $time, rsp_new_altitude, rsp_new_velocity);
            mismatches++;
         end else begin
            e = expected_estimates.pop_front();
            if (rsp_new_altitude !== e.alt) begin
               $display("%0t: new_altitude expected %h got %h", $time, e.alt,
                        rsp_new_altitude);
               mismatches++;
            end
            if (rsp_new_velocity !== e.vel) begin
               $display("%0t: new_velocity expected %h got %h", $time, e.vel,
                        rsp_new_velocity);
               mismatches++;
            end
         end
      end
   end

   initial begin
      script_row_type row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_baro_altitude = '0;
      req_prior_altitude = '0;
      req_prior_velocity = '0;
      req_vert_accel = '0;
      req_time_step = '0;
      csr_valid = 1'b0;
      csr_index = acfz_pkg::CSR_POS_GAIN;
      csr_data = '0;
      pos_gain = acfz_pkg::POS_GAIN_RST;
      vel_gain = acfz_pkg::VEL_GAIN_RST;
      still_thr = acfz_pkg::THRESHOLD_RST;
      for (int i = 0; i < acfz_pkg::WINDOW_LEN; i++) begin
         accel_hist[acfz_pkg::WIN_IDX_W'(i)] = '0;
      end
      hist_pos = '0;
      mismatches = 0;
      still_run = 0;
      hold_req = 1'b0;
      hold_done = 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 55;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = script_row(i);
         send_item(row.item, row.fixed_result, row.result);
      end

      for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(acfz_pkg::CSR_POS_GAIN, 32'h00008000);
               write_reg(acfz_pkg::CSR_VEL_GAIN, 32'h00000400);
               write_reg(acfz_pkg::CSR_THRESHOLD, 32'h00010000);
            end
            1: begin
               write_reg(acfz_pkg::CSR_POS_GAIN, 32'h0);
               write_reg(acfz_pkg::CSR_VEL_GAIN, 32'h0);
               write_reg(acfz_pkg::CSR_THRESHOLD, 32'h0);
            end
            2: begin
               write_reg(acfz_pkg::CSR_POS_GAIN, 32'h00FFFFFF);
               write_reg(acfz_pkg::CSR_VEL_GAIN, 32'h00FFFFFF);
               write_reg(acfz_pkg::CSR_THRESHOLD, 32'h7FFFFFFF);
            end
            3: begin
               // upper bits beyond each register are dropped, spare index ignored
               write_reg(acfz_pkg::CSR_POS_GAIN, 32'hFF012345);
               write_reg(acfz_pkg::CSR_VEL_GAIN, 32'h80000100);
               write_reg(acfz_pkg::CSR_THRESHOLD, 32'h80003000);
               write_reg(CSR_SPARE, 32'h0BADF00D);
            end
            4: begin
               write_reg(acfz_pkg::CSR_POS_GAIN, $urandom_range(0, 32'h00FFFFFF));
               write_reg(acfz_pkg::CSR_VEL_GAIN, $urandom_range(0, 32'h00FFFFFF));
               write_reg(acfz_pkg::CSR_THRESHOLD, $urandom_range(0, 32'h00100000));
            end
            default: begin
               write_reg(acfz_pkg::CSR_POS_GAIN, $urandom);
               write_reg(acfz_pkg::CSR_VEL_GAIN, 32'h00000001);
               write_reg(acfz_pkg::CSR_THRESHOLD, $urandom_range(0, 1000));
            end
         endcase
         if (ph < 2) begin
            send_idle_pct = 30;
            recv_idle_pct = 55;
         end else if (ph < 4) begin
            send_idle_pct = 55;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (ph == 1 && n == 20) hold_req = 1'b1;
            if (ph == 3 && n == 45) drain();
            send_item(random_item(), 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- altitude_complementary_filter_zupt.f -----
design/acfz_pkg.sv
design/acfz_seq.sv
design/acfz_win.sv
design/acfz_dp.sv
design/altitude_complementary_filter_zupt.sv
sim/altitude_complementary_filter_zupt_tb.sv
